[src/swrc_pkg.sv]
// Shared types and constants for the stop-and-wait receiver with checksum.
`default_nettype none
package swrc_pkg;

   localparam int SUM_W  = 32;
   localparam int CNT_W  = 6;
   localparam int BYTE_W = 8;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_ACK  = 2'd1,
      KIND_NACK = 2'd2
   } kind_type;

   typedef struct packed {
      logic     store;
      logic     clear;
      logic     rd_issue;
      logic     rd_advance;
      logic     load;
      kind_type kind;
      logic     last;
   } cmd_type;

   typedef struct packed {
      logic end_ok;
      logic last_byte;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

[src/swrc_req_if.sv]
// Request and response channel interfaces.
`default_nettype none
interface swrc_req_if;
   logic              valid;
   logic              ready;
   logic [7:0]        data_byte;
   logic              packet_end;
   logic signed [31:0] packet_sum;
   logic              final_packet;

   modport source (output valid, data_byte, packet_end, packet_sum, final_packet,
                   input ready);
   modport sink   (input valid, data_byte, packet_end, packet_sum, final_packet,
                   output ready);
endinterface

interface swrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       message_done;
   logic       run_last;

   modport source (output valid, kind, out_byte, message_done, run_last,
                   input ready);
   modport sink   (input valid, kind, out_byte, message_done, run_last,
                   output ready);
endinterface
`default_nettype wire

[src/stop_wait_receiver_checksum.sv]
// Top level of the stop-and-wait receiver with additive checksum.
//
// Usage:
//   req_bus carries one payload byte per transaction with packet_end, and on
//   the last byte the packet's checksum and its final-packet flag.
//   rsp_bus carries released bytes, then ACK, or a single NACK.
//   While a packet is filling, one byte is taken every cycle. On the last
//   byte the running sum is compared against packet_sum (signed byte sum,
//   32-bit wrap). A bad sum or more than MAX_PAYLOAD bytes gives one NACK,
//   loaded once the output register is free. A good packet is released
//   byte by byte, each byte going through the buffer read register, then
//   the output register, followed by the ACK. No new transaction is taken
//   until the ACK or NACK has been loaded into the output register.
//   A stalled rsp_bus holds the current transaction and pauses release.
//   Reset clears the count, sum, overrun flag, read pointer and output
//   valid; buffer contents are not cleared and need no clearing pass.
`default_nettype none
module stop_wait_receiver_checksum
   import swrc_pkg::*;
#(
   parameter int MAX_PAYLOAD = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   swrc_req_if.sink   req_bus,
   swrc_rsp_if.source rsp_bus
);

   cmd_type    cmd;
   status_type status;

   swrc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_packet_end (req_bus.packet_end),
      .req_ready      (req_bus.ready),
      .status         (status),
      .cmd            (cmd)
   );

   swrc_dp #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .data_byte        (req_bus.data_byte),
      .packet_end       (req_bus.packet_end),
      .packet_sum       (SUM_W'(req_bus.packet_sum)),
      .final_packet     (req_bus.final_packet),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_kind         (rsp_bus.kind),
      .rsp_out_byte     (rsp_bus.out_byte),
      .rsp_message_done (rsp_bus.message_done),
      .rsp_run_last     (rsp_bus.run_last)
   );

endmodule
`default_nettype wire

[src/swrc_ctrl.sv]
// Controller state machine: packet intake, checksum verdict and release sequencing.
`default_nettype none
module swrc_ctrl
   import swrc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_packet_end,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IN,
      S_NACK,
      S_READ,
      S_BYTE,
      S_ACK
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IN);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.kind       = KIND_BYTE;
      cmd.store      = accept;
      case (state_ff)
         S_IN: begin
            if (accept && req_packet_end) begin
               state_in = status.end_ok ? S_READ : S_NACK;
            end
         end
         S_NACK: begin
            if (status.out_free) begin
               cmd.load  = 1'b1;
               cmd.kind  = KIND_NACK;
               cmd.last  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = S_IN;
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_BYTE;
         end
         S_BYTE: begin
            if (status.out_free) begin
               cmd.load       = 1'b1;
               cmd.kind       = KIND_BYTE;
               cmd.rd_advance = 1'b1;
               state_in       = status.last_byte ? S_ACK : S_READ;
            end
         end
         S_ACK: begin
            if (status.out_free) begin
               cmd.load  = 1'b1;
               cmd.kind  = KIND_ACK;
               cmd.last  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = S_IN;
            end
         end
         default: state_in = S_IN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IN;
      end else begin
         state_ff <= state_in;
      end
   end

   a_nack_needs_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NACK && !status.out_free) |=> (state_ff == S_NACK))
      else $error("NACK state left without room in output register");

   a_read_then_byte: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_BYTE))
      else $error("buffer read not followed by byte emit");

   a_no_accept_in_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BYTE || state_ff == S_ACK || state_ff == S_NACK) |-> !req_ready)
      else $error("transaction accepted during response");

endmodule
`default_nettype wire

[src/swrc_dp.sv]
// Datapath: packet buffer, running sum, byte count and output register.
`default_nettype none
module swrc_dp
   import swrc_pkg::*;
#(
   parameter int MAX_PAYLOAD = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire logic              packet_end,
   input  wire logic [SUM_W-1:0]  packet_sum,
   input  wire logic              final_packet,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_kind,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_message_done,
   output logic                   rsp_run_last
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

   logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              overrun_ff, overrun_in;
   logic              fin_ff;
   logic [BYTE_W-1:0] rd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          kind_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              done_ff;
   logic              last_ff;

   logic              room;
   logic [SUM_W-1:0]  sum_next;

   assign room     = (count_ff < MAX_CNT);
   assign sum_next = sum_ff + {{(SUM_W-BYTE_W){data_byte[BYTE_W-1]}}, data_byte};

   assign status.end_ok    = room && !overrun_ff && (sum_next == packet_sum);
   assign status.last_byte = ((rd_ptr_ff + CNT_W'(1)) == count_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      count_in   = count_ff;
      sum_in     = sum_ff;
      overrun_in = overrun_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (cmd.store) begin
         sum_in = sum_next;
         if (room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            overrun_in = 1'b1;
         end
      end
      if (cmd.rd_advance) begin
         rd_ptr_in = rd_ptr_ff + CNT_W'(1);
      end
      if (cmd.clear) begin
         count_in   = '0;
         sum_in     = '0;
         overrun_in = 1'b0;
         rd_ptr_in  = '0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         overrun_ff   <= 1'b0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         overrun_ff   <= overrun_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store && room) begin
         mem[count_ff[AW-1:0]] <= data_byte;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[rd_ptr_ff[AW-1:0]];
      end
      if (cmd.store && packet_end) begin
         fin_ff <= final_packet;
      end
      if (cmd.load) begin
         kind_ff <= cmd.kind;
         byte_ff <= (cmd.kind == KIND_BYTE) ? rd_data_ff : '0;
         done_ff <= (cmd.kind == KIND_ACK) && fin_ff;
         last_ff <= cmd.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_message_done = done_ff;
   assign rsp_run_last     = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("byte count beyond buffer size");

   a_overrun_full: assert property (@(posedge clock) disable iff (reset)
      overrun_ff |-> (count_ff == MAX_CNT))
      else $error("overrun flagged with buffer not full");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      rd_ptr_ff <= count_ff)
      else $error("release pointer past stored bytes");

   a_done_on_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> (kind_ff == KIND_ACK && last_ff))
      else $error("message end flagged on a non-ACK transaction");

endmodule
`default_nettype wire
